FILE: rtl/core/mbgo_pkg.sv
// ----------------------------------------------------------------------------
// mbgo_pkg: shared types and constants of the bitmap to grayscale streamer
// Command codes, register indexes, reset values and the job record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package mbgo_pkg;

   // display controller codes
   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] GRAY_LEFT  = 8'hF0;
   localparam logic [7:0] GRAY_RIGHT = 8'h0F;

   // register indexes
   localparam logic [1:0] CSR_START_X   = 2'd0;
   localparam logic [1:0] CSR_START_ROW = 2'd1;
   localparam logic [1:0] CSR_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_HEIGHT    = 2'd3;

   // register reset values
   localparam logic [7:0] RST_START_X   = 8'd0;
   localparam logic [7:0] RST_START_ROW = 8'd0;
   localparam logic [8:0] RST_WIDTH     = 9'd16;
   localparam logic [7:0] RST_HEIGHT    = 8'd16;

   // output sequence steps: four commands, then four data bytes
   localparam logic [2:0] STEP_PAGE   = 3'd0;
   localparam logic [2:0] STEP_ROW    = 3'd1;
   localparam logic [2:0] STEP_COL_HI = 3'd2;
   localparam logic [2:0] STEP_COL_LO = 3'd3;
   localparam logic [2:0] STEP_DATA0  = 3'd4;
   localparam logic [2:0] STEP_DATA3  = 3'd7;

   // default depth of the job queue
   localparam int JOB_DEPTH = 4;

   // one classified request
   typedef struct packed {
      logic [7:0] bits;
      logic       with_cmd;
      logic [7:0] row_addr;
      logic [6:0] col;
      logic       done;
   } job_type;

   // job queue status
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

FILE: rtl/core/mono_bitmap_to_gray_oled_stream.sv
// ----------------------------------------------------------------------------
// mono_bitmap_to_gray_oled_stream: 1bpp bitmap to 4bpp grayscale OLED stream
// Expands each bitmap byte into four gray data bytes, with four address
// command bytes in front of the first byte of every row.
//
//   channel  direction  handshake          payload
//   req_     in         push / full        bitmap_byte
//   rsp_     out        empty / pop        out_byte, is_command, run_last,
//                                          picture_done
//   csr_     in         wr_en              index, wdata (9 bits)
//
// A request yields four result bytes, eight on the first byte of a row; the
// back end's output register emits one byte per cycle while the rsp_ side pops.
// Reset (synchronous) restores register defaults, zeroes the counters and
// empties the job queue; no clearing pass is needed.
// A stalled rsp_ side fills the job queue of JOB_DEPTH entries before full
// rises; the front end keeps accepting until then.
// ----------------------------------------------------------------------------
module mono_bitmap_to_gray_oled_stream #(
   parameter int JOB_DEPTH = mbgo_pkg::JOB_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_wdata,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_bitmap_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_command,
   output logic       rsp_run_last,
   output logic       rsp_picture_done
);
   import mbgo_pkg::*;

   job_type       push_job;
   job_type       head_job;
   fifo_stat_type fifo_stat;
   logic          job_push;
   logic          job_pop;

   assign req_full = fifo_stat.full;

   // classify requests
   mbgo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_bitmap_byte (req_bitmap_byte),
      .fifo_stat       (fifo_stat),
      .job_push        (job_push),
      .job_out         (push_job)
   );

   // queue jobs
   mbgo_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (fifo_stat)
   );

   // emit bytes
   mbgo_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .fifo_stat        (fifo_stat),
      .job_pop          (job_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_run_last     (rsp_run_last),
      .rsp_picture_done (rsp_picture_done)
   );

   // last byte of a request is always pixel data
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_run_last) |-> !rsp_is_command)
      else $error("run_last on a command byte");

   // the back end takes jobs only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !fifo_stat.empty)
      else $error("job popped from empty queue");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result present after reset");

endmodule

FILE: rtl/core/mbgo_front.sv
// ----------------------------------------------------------------------------
// mbgo_front: request intake and classification
// Holds the registers and the row/byte counters, and turns each accepted
// request into a job record for the queue.
// ----------------------------------------------------------------------------
module mbgo_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_wdata,
   input  logic                   req_push,
   input  logic [7:0]             req_bitmap_byte,
   input  mbgo_pkg::fifo_stat_type fifo_stat,
   output logic                   job_push,
   output mbgo_pkg::job_type      job_out
);
   import mbgo_pkg::*;

   logic [7:0] start_x_ff,   start_x_in;
   logic [7:0] start_row_ff, start_row_in;
   logic [8:0] width_ff,     width_in;
   logic [7:0] height_ff,    height_in;
   logic [5:0] byte_in_row_ff, byte_in_row_in;
   logic [7:0] row_count_ff,   row_count_in;

   logic [9:0] bpr_sum;
   logic [6:0] bytes_per_row;
   logic [6:0] last_byte;
   logic [7:0] last_row;
   logic       row_end;
   logic       pic_end;

   // write registers
   always_comb begin
      start_x_in   = start_x_ff;
      start_row_in = start_row_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_X:   start_x_in   = csr_wdata[7:0];
            CSR_START_ROW: start_row_in = csr_wdata[7:0];
            CSR_WIDTH:     width_in     = csr_wdata;
            CSR_HEIGHT:    height_in    = csr_wdata[7:0];
            default:       start_x_in   = start_x_ff;
         endcase
      end
   end

   // classify the position of this request in the picture
   assign bpr_sum       = {1'b0, width_ff} + 10'd7;
   assign bytes_per_row = bpr_sum[9:3];
   assign last_byte     = (bytes_per_row == 7'd0) ? 7'd0 : bytes_per_row - 7'd1;
   assign last_row      = (height_ff == 8'd0) ? 8'd0 : height_ff - 8'd1;
   assign row_end       = {1'b0, byte_in_row_ff} >= last_byte;
   assign pic_end       = row_end && (row_count_ff >= last_row);

   assign job_push = req_push && !fifo_stat.full;

   // build the job record
   always_comb begin
      job_out.bits     = req_bitmap_byte;
      job_out.with_cmd = (byte_in_row_ff == 6'd0);
      job_out.row_addr = start_row_ff + row_count_ff;
      job_out.col      = start_x_ff[7:1];
      job_out.done     = pic_end;
   end

   // advance the counters on each accepted request
   always_comb begin
      byte_in_row_in = byte_in_row_ff;
      row_count_in   = row_count_ff;
      if (job_push) begin
         if (pic_end) begin
            byte_in_row_in = 6'd0;
            row_count_in   = 8'd0;
         end else if (row_end) begin
            byte_in_row_in = 6'd0;
            row_count_in   = row_count_ff + 8'd1;
         end else begin
            byte_in_row_in = byte_in_row_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= RST_START_X;
         start_row_ff   <= RST_START_ROW;
         width_ff       <= RST_WIDTH;
         height_ff      <= RST_HEIGHT;
         byte_in_row_ff <= 6'd0;
         row_count_ff   <= 8'd0;
      end else begin
         start_x_ff     <= start_x_in;
         start_row_ff   <= start_row_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         byte_in_row_ff <= byte_in_row_in;
         row_count_ff   <= row_count_in;
      end
   end

endmodule

FILE: rtl/core/mbgo_fifo.sv
// ----------------------------------------------------------------------------
// mbgo_fifo: job queue between front end and back end
// Small register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module mbgo_fifo #(
   parameter int DEPTH = mbgo_pkg::JOB_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mbgo_pkg::job_type       push_job,
   input  logic                    pop,
   output mbgo_pkg::job_type       head_job,
   output mbgo_pkg::fifo_stat_type stat
);
   import mbgo_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   job_type       slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_FULL);
   assign head_job   = slots_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/mbgo_back.sv
// ----------------------------------------------------------------------------
// mbgo_back: byte sequencer
// Takes jobs from the queue and emits the command and gray data bytes one
// per cycle into the output register whenever that register is free.
// ----------------------------------------------------------------------------
module mbgo_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mbgo_pkg::job_type       head_job,
   input  mbgo_pkg::fifo_stat_type fifo_stat,
   output logic                    job_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_is_command,
   output logic                    rsp_run_last,
   output logic                    rsp_picture_done
);
   import mbgo_pkg::*;

   job_type    job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       cmd_ff, last_ff, done_ff;

   logic       out_free;
   logic       emit;
   logic       finishing;
   logic [2:0] even_idx, odd_idx;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = busy_ff && out_free;
   assign finishing = emit && (step_ff == STEP_DATA3);
   assign job_pop   = (!busy_ff || finishing) && !fifo_stat.empty;

   assign even_idx = {step_ff[1:0], 1'b0};
   assign odd_idx  = {step_ff[1:0], 1'b1};

   // select the byte for the current step
   always_comb begin
      case (step_ff)
         STEP_PAGE:   byte_in = CMD_PAGE;
         STEP_ROW:    byte_in = job_ff.row_addr;
         STEP_COL_HI: byte_in = CMD_COL_HI | {5'd0, job_ff.col[6:4]};
         STEP_COL_LO: byte_in = {4'd0, job_ff.col[3:0]};
         default:     byte_in = (job_ff.bits[even_idx] ? GRAY_LEFT  : 8'h00) |
                                (job_ff.bits[odd_idx]  ? GRAY_RIGHT : 8'h00);
      endcase
   end

   // step through the job and load the next one
   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (emit) begin
         out_valid_in = 1'b1;
         step_in      = step_ff + 3'd1;
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = head_job;
         step_in = head_job.with_cmd ? STEP_PAGE : STEP_DATA0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_PAGE;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold job and output payload
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         byte_ff <= byte_in;
         cmd_ff  <= !step_ff[2];
         last_ff <= (step_ff == STEP_DATA3);
         done_ff <= job_ff.done;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_is_command   = cmd_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_picture_done = done_ff;

endmodule

FILE: sim/mono_bitmap_to_gray_oled_stream_tb.sv
// ----------------------------------------------------------------------------
// mono_bitmap_to_gray_oled_stream_tb: self-checking bench of the OLED streamer
// Feeds bitmap bytes through the push/full queue port and pops the command
// and gray data bytes from the empty/pop port. A scoreboard object mirrors
// the row and byte counters and the address registers, builds the expected
// byte sequence for every accepted request and checks each popped byte field
// by field. Directed pictures cover the size extremes and mid-picture resizing;
// random segments follow, with idle patterns on both sides.
// ----------------------------------------------------------------------------
module mono_bitmap_to_gray_oled_stream_tb;
   import mbgo_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   // one byte bound for the display controller
   typedef struct {
      logic [7:0] out_byte;
      logic       is_command;
      logic       run_last;
      logic       picture_done;
   } oled_byte_type;

   // mirror of the streamer: registers, counters and the bytes still owed
   class oled_stream_board;
      logic [7:0] start_x;
      logic [7:0] start_row;
      logic [8:0] width_pixels;
      logic [7:0] height_rows;
      logic [5:0] byte_in_row;
      logic [7:0] row_count;
      oled_byte_type owed_bytes[$];
      int         mismatches;

      function new();
         start_x      = RST_START_X;
         start_row    = RST_START_ROW;
         width_pixels = RST_WIDTH;
         height_rows  = RST_HEIGHT;
         byte_in_row  = '0;
         row_count    = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [8:0] value);
         case (idx)
            CSR_START_X:   start_x = value[7:0];
            CSR_START_ROW: start_row = value[7:0];
            CSR_WIDTH:     width_pixels = value;
            CSR_HEIGHT:    height_rows = value[7:0];
            default: ;
         endcase
      endfunction

      function void add_byte(logic [7:0] value, logic cmd, logic last, logic done);
         oled_byte_type e;
         e.out_byte     = value;
         e.is_command   = cmd;
         e.run_last     = last;
         e.picture_done = done;
         owed_bytes.push_back(e);
      endfunction

      // expand one accepted bitmap byte and advance the counters
      function void note_request(logic [7:0] bits);
         int         per_row;
         int         rows;
         logic       row_end;
         logic       pic_end;
         logic [6:0] col;
         logic [7:0] gray;
         int         k;
         per_row = (int'(width_pixels) + 7) >> 3;
         if (per_row == 0) per_row = 1;
         rows = int'(height_rows);
         if (rows == 0) rows = 1;
         row_end = (int'(byte_in_row) >= per_row - 1);
         pic_end = row_end && (int'(row_count) >= rows - 1);
         col = start_x[7:1];

         // address commands lead the first byte of a row
         if (byte_in_row == 6'd0) begin
            add_byte(CMD_PAGE, 1'b1, 1'b0, pic_end);
            add_byte(start_row + row_count, 1'b1, 1'b0, pic_end);
            add_byte(CMD_COL_HI | {5'b0, col[6:4]}, 1'b1, 1'b0, pic_end);
            add_byte({4'b0, col[3:0]}, 1'b1, 1'b0, pic_end);
         end

         // two pixels per data byte, left pixel in the high nibble
         for (k = 0; k < 4; k++) begin
            gray = 8'h00;
            if (bits[2*k]) gray = GRAY_LEFT;
            if (bits[2*k+1]) gray = gray | GRAY_RIGHT;
            add_byte(gray, 1'b0, k == 3, pic_end);
         end

         if (pic_end) begin
            byte_in_row = '0;
            row_count   = '0;
         end else if (row_end) begin
            byte_in_row = '0;
            row_count   = row_count + 8'd1;
         end else begin
            byte_in_row = byte_in_row + 6'd1;
         end
      endfunction

      // compare a popped byte with the oldest owed one
      function void check_byte(logic [7:0] out_byte, logic cmd, logic last, logic done);
         oled_byte_type e;
         if (owed_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h cmd %b last %b done %b",
                     $time, out_byte, cmd, last, done);
            mismatches++;
            return;
         end
         e = owed_bytes.pop_front();
         if (out_byte !== e.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, out_byte);
            mismatches++;
         end
         if (cmd !== e.is_command) begin
            $display("%0t: is_command expected %b actual %b", $time, e.is_command, cmd);
            mismatches++;
         end
         if (last !== e.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, e.run_last, last);
            mismatches++;
         end
         if (done !== e.picture_done) begin
            $display("%0t: picture_done expected %b actual %b",
                     $time, e.picture_done, done);
            mismatches++;
         end
      endfunction

      function int waiting();
         return owed_bytes.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_bitmap_byte = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_command;
   logic       rsp_run_last;
   logic       rsp_picture_done;

   oled_stream_board board;
   int send_idle = 31;
   int recv_idle = 45;
   int cycle_count = 0;

   mono_bitmap_to_gray_oled_stream u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_bitmap_byte  (req_bitmap_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_run_last     (rsp_run_last),
      .rsp_picture_done (rsp_picture_done)
   );

   always #5 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** mono_bitmap_to_gray_oled_stream: FAILED **");
         $finish;
      end
   end

   // pop side: check each accepted byte, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_byte(rsp_out_byte, rsp_is_command, rsp_run_last, rsp_picture_done);
      rsp_pop <= ($urandom_range(99) >= recv_idle);
   end

   // write one register; drops the write enable again before returning
   task automatic write_reg(logic [1:0] idx, logic [8:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   // hold off requests until every owed byte has been popped
   task automatic wait_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (board.waiting() != 0);
      repeat (4) @(posedge clock);
   endtask

   // idle at random cycle by cycle, then offer one request and hold it until accepted
   task automatic push_bitmap(logic [7:0] bits);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_bitmap_byte <= bits;
      do @(posedge clock); while (req_full);
      board.note_request(bits);
   endtask

   // rewrite a random subset of the registers, extremes included
   task automatic write_random_setup();
      logic [8:0] width;
      logic [7:0] height;
      case ($urandom_range(9))
         0:       width = 9'd0;
         1:       width = 9'd511;
         2:       width = 9'd256;
         3:       width = 9'($urandom_range(1, 8));
         default: width = 9'($urandom_range(1, 64));
      endcase
      case ($urandom_range(7))
         0:       height = 8'd0;
         1:       height = 8'd255;
         2:       height = 8'd1;
         default: height = 8'($urandom_range(1, 6));
      endcase
      if ($urandom_range(9) < 7)
         write_reg(CSR_START_X, ($urandom_range(3) == 0) ?
                   ($urandom_range(1) ? 9'd255 : 9'd0) : 9'($urandom_range(255)));
      if ($urandom_range(9) < 7)
         write_reg(CSR_START_ROW, ($urandom_range(3) == 0) ?
                   ($urandom_range(1) ? 9'd255 : 9'd0) : 9'($urandom_range(255)));
      if ($urandom_range(9) < 7) write_reg(CSR_WIDTH, width);
      if ($urandom_range(9) < 7) write_reg(CSR_HEIGHT, {1'b0, height});
   endtask

   initial begin
      int seg;
      int n;
      int i;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: two bytes per row, extremes of the bitmap byte
      push_bitmap(8'h00);
      push_bitmap(8'hFF);
      push_bitmap(8'h55);
      push_bitmap(8'hAA);
      wait_drain();

      // one-byte picture at the far corner: every byte ends the picture
      write_reg(CSR_START_X, 9'd255);
      write_reg(CSR_START_ROW, 9'd255);
      write_reg(CSR_WIDTH, 9'd1);
      write_reg(CSR_HEIGHT, 9'd1);
      push_bitmap(8'h01);
      push_bitmap(8'h80);
      push_bitmap(8'hC3);
      wait_drain();

      // zero width and zero height fall back to one byte, one row
      write_reg(CSR_WIDTH, 9'd0);
      write_reg(CSR_HEIGHT, 9'd0);
      push_bitmap(8'h3C);
      push_bitmap(8'h02);
      wait_drain();

      // full 2x2 picture then the start of the next
      write_reg(CSR_START_X, 9'd90);
      write_reg(CSR_START_ROW, 9'd0);
      write_reg(CSR_WIDTH, 9'd9);
      write_reg(CSR_HEIGHT, 9'd2);
      for (i = 0; i < 5; i++) push_bitmap(8'($urandom_range(255)));
      wait_drain();

      // shrink the width mid-row: the row ends at once
      write_reg(CSR_WIDTH, 9'd24);
      push_bitmap(8'h0F);
      wait_drain();
      write_reg(CSR_WIDTH, 9'd8);
      push_bitmap(8'hF0);
      push_bitmap(8'h99);
      wait_drain();

      // shrink the height mid-picture: the picture ends at once
      write_reg(CSR_HEIGHT, 9'd3);
      push_bitmap(8'h66);
      wait_drain();
      write_reg(CSR_HEIGHT, 9'd1);
      push_bitmap(8'h81);
      wait_drain();

      // random segments, idle pattern per phase
      for (seg = 0; seg < 8; seg++) begin
         if (seg < 3) begin
            send_idle = 31;
            recv_idle = 45;
         end else if (seg < 6) begin
            send_idle = 45;
            recv_idle = 31;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_random_setup();
         n = $urandom_range(40, 60);
         for (i = 0; i < n; i++) begin
            // let the pop side run dry once mid-stream
            if (seg == 4 && i == n / 2) wait_drain();
            push_bitmap(8'($urandom_range(255)));
         end
         wait_drain();
      end

      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.waiting() == 0)
         $display("** mono_bitmap_to_gray_oled_stream: PASSED **");
      else
         $display("** mono_bitmap_to_gray_oled_stream: FAILED **");
      $finish;
   end

endmodule
